/* design/sorted_table_binary_lookup_top_defines.svh */
// ---------------------------------------------------------------------------
// Sorted table binary lookup: assertion macros
// Shared helpers for the concurrent checks of the lookup block.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_LOOKUP_TOP_DEFINES_SVH
`define SORTED_TABLE_BINARY_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STBL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/stbl_pkg.sv */
// ---------------------------------------------------------------------------
// stbl_pkg
// Types and constants shared by the sorted table lookup modules.
// ---------------------------------------------------------------------------
package stbl_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W    = 9;
   localparam int NUM_W      = 16;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 2;

   // Register byte addresses.
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_COUNT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_USAGE_MASK  = 3'd4;

   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 9'd256;
   localparam logic [NUM_W-1:0]   USAGE_MASK_RESET  = 16'd1;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_USAGE = 2'd2;

   typedef struct packed {
      logic             command;
      logic [POS_W-1:0] entry_index;
      logic [NUM_W-1:0] entry_number;
      logic [NUM_W-1:0] entry_usage;
      logic [NUM_W-1:0] search_key;
      logic             check_usage;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]    found_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WDONE,
      ST_FIRST,
      ST_STEP,
      ST_CHECK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic first_probe;
      logic step_probe;
      logic post_write;
      logic post_lookup;
   } dp_cmd_type;

endpackage

/* design/stbl_csr.sv */
// ---------------------------------------------------------------------------
// stbl_csr
// Configuration registers behind an APB-style port.
// ---------------------------------------------------------------------------
module stbl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [stbl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [stbl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [stbl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [stbl_pkg::COUNT_W-1:0]     entry_count,
   output logic [stbl_pkg::NUM_W-1:0]       usage_mask
);

   logic [stbl_pkg::COUNT_W-1:0] entry_count_ff;
   logic [stbl_pkg::NUM_W-1:0]   usage_mask_ff;
   logic                         wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= stbl_pkg::ENTRY_COUNT_RESET;
         usage_mask_ff  <= stbl_pkg::USAGE_MASK_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr)
            stbl_pkg::REG_ENTRY_COUNT: begin
               entry_count_ff <= csr_pwdata[stbl_pkg::COUNT_W-1:0];
            end
            stbl_pkg::REG_USAGE_MASK: begin
               usage_mask_ff <= csr_pwdata[stbl_pkg::NUM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         stbl_pkg::REG_ENTRY_COUNT: begin
            csr_prdata = stbl_pkg::CSR_DATA_W'(entry_count_ff);
         end
         stbl_pkg::REG_USAGE_MASK: begin
            csr_prdata = stbl_pkg::CSR_DATA_W'(usage_mask_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign entry_count = entry_count_ff;
   assign usage_mask  = usage_mask_ff;

endmodule

/* design/stbl_dp.sv */
// ---------------------------------------------------------------------------
// stbl_dp
// Table memories, probe registers and result register of the lookup.
// ---------------------------------------------------------------------------
module stbl_dp #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  stbl_pkg::req_type             req_data,
   input  logic [stbl_pkg::COUNT_W-1:0]  entry_count,
   input  logic [stbl_pkg::NUM_W-1:0]    usage_mask,
   input  stbl_pkg::dp_cmd_type          cmd,
   output logic                          last_probe,
   output stbl_pkg::rsp_type             rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int EW    = (CNT_W > stbl_pkg::COUNT_W) ? CNT_W : stbl_pkg::COUNT_W;

   logic [stbl_pkg::NUM_W-1:0] num_mem [TABLE_DEPTH];
   logic [stbl_pkg::NUM_W-1:0] use_mem [TABLE_DEPTH];

   logic [stbl_pkg::NUM_W-1:0] key_ff;
   logic                       check_ff;
   logic [CNT_W-1:0]           n_ff;
   logic [IDX_W-1:0]           i_ff;
   logic [IDX_W-1:0]           i_in;
   logic [IDX_W-1:0]           w_ff;
   logic [IDX_W-1:0]           w_in;
   logic [stbl_pkg::NUM_W-1:0] rd_num_ff;
   logic [stbl_pkg::NUM_W-1:0] rd_use_ff;
   stbl_pkg::rsp_type          rsp_ff;
   stbl_pkg::rsp_type          lookup_rsp;

   logic [EW-1:0]              cnt_ext;
   logic [EW-1:0]              n_sat;
   logic [CNT_W-1:0]           n_eff;
   logic [IDX_W-1:0]           nm1;
   logic [IDX_W-1:0]           w_top;
   logic [IDX_W-1:0]           rd_addr;
   logic                       geq;
   logic                       hit;
   logic                       wr_en;

   // Effective count and the first probe: the highest power of two
   // not above count minus one.
   always_comb begin
      cnt_ext = EW'(entry_count);
      if (cnt_ext < EW'(2)) begin
         n_sat = EW'(2);
      end else if (cnt_ext > EW'(TABLE_DEPTH)) begin
         n_sat = EW'(TABLE_DEPTH);
      end else begin
         n_sat = cnt_ext;
      end
      n_eff = CNT_W'(n_sat);
      nm1   = IDX_W'(n_eff - CNT_W'(1));
      w_top = '0;
      for (int b = 0; b < IDX_W; b++) begin
         if (nm1[b]) begin
            w_top = IDX_W'(1) << b;
         end
      end
   end

   assign geq        = key_ff >= rd_num_ff;
   assign last_probe = (w_ff == IDX_W'(1));

   // The read address is the next probe, so its data is registered for the next cycle.
   always_comb begin
      i_in    = i_ff;
      w_in    = w_ff;
      rd_addr = i_ff;
      if (cmd.load_req) begin
         rd_addr = w_top;
      end else if (cmd.first_probe || cmd.step_probe) begin
         if (cmd.first_probe) begin
            i_in = geq ? IDX_W'(n_ff - CNT_W'(w_ff)) : '0;
         end else begin
            i_in = geq ? i_ff + w_ff : i_ff;
         end
         w_in    = w_ff >> 1;
         rd_addr = last_probe ? i_in : i_in + w_in;
      end
   end

   assign wr_en = cmd.load_req && (req_data.command == stbl_pkg::CMD_WRITE) &&
                  (int'(req_data.entry_index) < TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         num_mem[IDX_W'(req_data.entry_index)] <= req_data.entry_number;
         use_mem[IDX_W'(req_data.entry_index)] <= req_data.entry_usage;
      end
      rd_num_ff <= num_mem[rd_addr];
      rd_use_ff <= use_mem[rd_addr];
   end

   assign hit = (rd_num_ff == key_ff);

   always_comb begin
      lookup_rsp.found_index = '0;
      lookup_rsp.status      = stbl_pkg::STATUS_MISS;
      if (hit) begin
         lookup_rsp.found_index = stbl_pkg::POS_W'(i_ff);
         if (check_ff && ((rd_use_ff & usage_mask) == '0)) begin
            lookup_rsp.status = stbl_pkg::STATUS_USAGE;
         end else begin
            lookup_rsp.status = stbl_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff   <= req_data.search_key;
         check_ff <= req_data.check_usage;
         n_ff     <= n_eff;
         w_ff     <= w_top;
      end else if (cmd.first_probe || cmd.step_probe) begin
         i_ff <= i_in;
         w_ff <= w_in;
      end
      if (cmd.post_write) begin
         rsp_ff.found_index <= '0;
         rsp_ff.status      <= stbl_pkg::STATUS_OK;
      end else if (cmd.post_lookup) begin
         rsp_ff <= lookup_rsp;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* design/stbl_ctrl.sv */
// ---------------------------------------------------------------------------
// stbl_ctrl
// Sequencer for writes and binary-search lookups, and result valid.
// ---------------------------------------------------------------------------
module stbl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_command,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  last_probe,
   output stbl_pkg::dp_cmd_type  cmd
);

   stbl_pkg::state_type state_ff;
   stbl_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         stbl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_command == stbl_pkg::CMD_WRITE) ?
                          stbl_pkg::ST_WDONE : stbl_pkg::ST_FIRST;
            end
         end
         stbl_pkg::ST_WDONE: begin
            if (out_free) begin
               state_in = stbl_pkg::ST_IDLE;
            end
         end
         stbl_pkg::ST_FIRST, stbl_pkg::ST_STEP: begin
            state_in = last_probe ? stbl_pkg::ST_CHECK : stbl_pkg::ST_STEP;
         end
         stbl_pkg::ST_CHECK: begin
            if (out_free) begin
               state_in = stbl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stbl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         stbl_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         stbl_pkg::ST_WDONE: begin
            cmd.post_write = out_free;
         end
         stbl_pkg::ST_FIRST: begin
            cmd.first_probe = 1'b1;
         end
         stbl_pkg::ST_STEP: begin
            cmd.step_probe = 1'b1;
         end
         stbl_pkg::ST_CHECK: begin
            cmd.post_lookup = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post_write || cmd.post_lookup) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stbl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/sorted_table_binary_lookup_top.sv */
// ---------------------------------------------------------------------------
// sorted_table_binary_lookup_top
// Sorted register table with binary lookup and optional usage check.
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    stbl_pkg::req_type (write or lookup)
// rsp       out        rsp_valid/rsp_ready    stbl_pkg::rsp_type (index, status)
// csr       in         APB-style, pready = 1  entry_count @0x0, usage mask @0x4
//
// A write item passes through accept and a write-done state. A lookup passes through
// accept, one probe state per halving of the search window and the compare, bound by
// the single read port of the table and its read register.
// A new item is taken while the previous result still waits in the output
// register; a stalled result holds the block in its last state until it drains.
// Reset clears the controller and the CSRs but not the table or the datapath registers.
// ---------------------------------------------------------------------------
`include "sorted_table_binary_lookup_top_defines.svh"

module sorted_table_binary_lookup_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  stbl_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output stbl_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [stbl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [stbl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [stbl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   logic [stbl_pkg::COUNT_W-1:0] entry_count;
   logic [stbl_pkg::NUM_W-1:0]   usage_mask;
   stbl_pkg::dp_cmd_type         dp_cmd;
   logic                         last_probe;
   logic                         req_fire;
   logic                         rsp_miss;
   logic                         index_zero;

   stbl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .entry_count (entry_count),
      .usage_mask  (usage_mask)
   );

   stbl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .last_probe  (last_probe),
      .cmd         (dp_cmd)
   );

   stbl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .req_data    (req_data),
      .entry_count (entry_count),
      .usage_mask  (usage_mask),
      .cmd         (dp_cmd),
      .last_probe  (last_probe),
      .rsp_data    (rsp_data)
   );

   assign req_fire   = req_valid && req_ready;
   assign rsp_miss   = rsp_valid && (rsp_data.status == stbl_pkg::STATUS_MISS);
   assign index_zero = (rsp_data.found_index == '0);

   // An accepted item keeps the block busy for at least the next cycle.
   `STBL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "early accept")

   // A miss never carries an index.
   `STBL_ASSERT_NOW(a_miss_index_zero, clock, reset, rsp_miss, index_zero, "miss with index")

   // The controller issues at most one datapath command per cycle.
   `STBL_ASSERT_NOW(a_one_command, clock, reset, 1'b1, $onehot0(dp_cmd), "overlapping commands")

endmodule

/* verif/sorted_table_binary_lookup_top_test.sv */
// ---------------------------------------------------------------------------
// sorted_table_binary_lookup_top_test
// Self-checking bench for the sorted table lookup block. A short table of
// directed items loads a four-entry table and probes hits, misses, usage
// failures and an unsorted table. Random phases follow: each one writes the
// count and mask registers while the block is idle, loads a fresh ascending
// table unless a large one is loaded, mixes lookups with stray writes and
// checks each result against a scripted answer or an in-bench binary search.
// ---------------------------------------------------------------------------
module sorted_table_binary_lookup_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import stbl_pkg::*;

   localparam int DEPTH        = 256;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int IDLE_PCT     = 18;
   localparam int HOLD_CYCLES  = 300;
   localparam int FORCED       = 7;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type answer;
   } script_row;

   // Count 4, mask 1. Rows with typed cleared take their answer from the predictor.
   localparam script_row SCRIPT [17] = '{
      '{'{CMD_WRITE,  8'd0,  16'h0000, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, '{8'd0, STATUS_OK}},
      '{'{CMD_WRITE,  8'd1,  16'h0010, 16'h0000, 16'h0000, 1'b0}, 1'b1, '{8'd0, STATUS_OK}},
      '{'{CMD_WRITE,  8'd2,  16'h8000, 16'h0001, 16'hFFFF, 1'b0}, 1'b1, '{8'd0, STATUS_OK}},
      '{'{CMD_WRITE,  8'd3,  16'hFFFF, 16'h8000, 16'h0000, 1'b1}, 1'b1, '{8'd0, STATUS_OK}},
      '{'{CMD_WRITE,  8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, '{8'd0, STATUS_OK}},
      '{'{CMD_LOOKUP, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1}, 1'b1, '{8'd0, STATUS_OK}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b1}, 1'b1, '{8'd3, STATUS_USAGE}},
      '{'{CMD_LOOKUP, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1, '{8'd3, STATUS_OK}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h0010, 1'b1}, 1'b1, '{8'd1, STATUS_USAGE}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h0010, 1'b0}, 1'b1, '{8'd1, STATUS_OK}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h8000, 1'b1}, 1'b1, '{8'd2, STATUS_OK}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h0011, 1'b1}, 1'b1, '{8'd0, STATUS_MISS}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h7FFF, 1'b0}, 1'b1, '{8'd0, STATUS_MISS}},
      // Entry 1 now lies above entry 2, so the table is no longer sorted.
      '{'{CMD_WRITE,  8'd1,  16'h9000, 16'h0001, 16'h0000, 1'b0}, 1'b1, '{8'd0, STATUS_OK}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h9000, 1'b1}, 1'b0, '{8'd0, STATUS_OK}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h8000, 1'b1}, 1'b0, '{8'd0, STATUS_OK}},
      '{'{CMD_LOOKUP, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, '{8'd0, STATUS_OK}}
   };

   localparam logic [COUNT_W-1:0] FORCED_COUNT [FORCED] = '{
      9'd0, 9'd511, 9'd2, 9'd256, 9'd257, 9'd1, 9'd3
   };
   localparam logic [NUM_W-1:0] FORCED_MASK [FORCED] = '{
      16'h0000, 16'hFFFF, 16'h8000, 16'h00F0, 16'h0001, 16'h0400, 16'hFFFF
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the block's table and registers.
   logic [NUM_W-1:0]   number_copy [DEPTH];
   logic [NUM_W-1:0]   usage_copy [DEPTH];
   bit                 written [DEPTH];
   logic [COUNT_W-1:0] count_copy = ENTRY_COUNT_RESET;
   logic [NUM_W-1:0]   mask_copy  = USAGE_MASK_RESET;

   rsp_type pending_answers [$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   int      random_items   = 0;
   bit      quiet          = 1'b0;
   bit      hold_request   = 1'b0;
   bit      hold_done      = 1'b0;
   int      hold_left      = 0;

   sorted_table_binary_lookup_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_table_binary_lookup_top regression: fail");
         $finish;
      end
   end

   function automatic int effective_entries(input logic [COUNT_W-1:0] count);
      if (count < 2) return 2;
      if (count > DEPTH) return DEPTH;
      return int'(count);
   endfunction

   function automatic bit entries_ready(input int n);
      for (int k = 0; k < n; k++)
         if (!written[k]) return 1'b0;
      return 1'b1;
   endfunction

   // Applies one item to the shadow table and returns the result it causes.
   function automatic rsp_type predict_rsp(input req_type r);
      rsp_type res;
      int      n;
      int      w;
      int      i;
      res.found_index = '0;
      res.status      = STATUS_OK;
      if (r.command == CMD_WRITE) begin
         number_copy[r.entry_index] = r.entry_number;
         usage_copy[r.entry_index]  = r.entry_usage;
         written[r.entry_index]     = 1'b1;
         return res;
      end
      n = effective_entries(count_copy);
      w = 1;
      while ((w << 1) <= n - 1) w = w << 1;
      // The first probe picks the upper or lower window, then the step halves.
      i = (r.search_key >= number_copy[w]) ? n - w : 0;
      for (w = w >> 1; w > 0; w = w >> 1)
         if (r.search_key >= number_copy[i + w]) i = i + w;
      if (number_copy[i] != r.search_key) begin
         res.status = STATUS_MISS;
      end else begin
         res.found_index = POS_W'(i);
         if (r.check_usage && (usage_copy[i] & mask_copy) == '0) res.status = STATUS_USAGE;
      end
      return res;
   endfunction

   function automatic logic [NUM_W-1:0] sparse_bits();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return NUM_W'(1) << $urandom_range(0, NUM_W - 1);
         default: return NUM_W'($urandom());
      endcase
   endfunction

   function automatic req_type write_item(input int idx, input logic [NUM_W-1:0] number,
                                          input logic [NUM_W-1:0] usage_bits);
      req_type r;
      r.command      = CMD_WRITE;
      r.entry_index  = POS_W'(idx);
      r.entry_number = number;
      r.entry_usage  = usage_bits;
      r.search_key   = NUM_W'($urandom());
      r.check_usage  = 1'($urandom());
      return r;
   endfunction

   function automatic req_type lookup_item(input logic [NUM_W-1:0] key);
      req_type r;
      r.command      = CMD_LOOKUP;
      r.entry_index  = POS_W'($urandom());
      r.entry_number = NUM_W'($urandom());
      r.entry_usage  = NUM_W'($urandom());
      r.search_key   = key;
      r.check_usage  = 1'($urandom());
      return r;
   endfunction

   // Result side: random stalls, plus one long hold counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result, index %0d status %0d", $time,
                     rsp_data.found_index, rsp_data.status);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.found_index !== want.found_index) begin
               $display("%0t: found_index expected %0d actual %0d", $time,
                        want.found_index, rsp_data.found_index);
               mismatch_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_data.status);
               mismatch_count++;
            end
         end
      end
   end

   task automatic offer(input req_type r, input bit typed, input rsp_type answer);
      rsp_type predicted;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = predict_rsp(r);
      pending_answers.push_back(typed ? answer : predicted);
      if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_cycle(1'b0, addr, '0, got);
      if (got !== want) begin
         $display("%0t: register 0x%0h expected 0x%0h actual 0x%0h", $time, addr, want, got);
         mismatch_count++;
      end
   endtask

   // Upper data bits are random; only the register's own width is kept.
   task automatic configure(input logic [COUNT_W-1:0] count, input logic [NUM_W-1:0] mask);
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_DATA_W-1:0] ignored;
      data = $urandom();
      data[COUNT_W-1:0] = count;
      csr_cycle(1'b1, REG_ENTRY_COUNT, data, ignored);
      count_copy = count;
      data = $urandom();
      data[NUM_W-1:0] = mask;
      csr_cycle(1'b1, REG_USAGE_MASK, data, ignored);
      mask_copy = mask;
      check_register(REG_ENTRY_COUNT, CSR_DATA_W'(count));
      check_register(REG_USAGE_MASK, CSR_DATA_W'(mask));
   endtask

   // Loads entries 0..n-1 with an ascending sequence; tight steps give duplicates.
   task automatic fill_entries(input int n);
      logic [NUM_W-1:0] values [DEPTH];
      int               step_max;
      int               value;
      int               idx;
      bit               descending;
      step_max   = ($urandom_range(0, 3) == 0) ? 2 : 65535 / n;
      value      = $urandom_range(0, 65535 - (n - 1) * step_max);
      descending = 1'($urandom());
      for (int k = 0; k < n; k++) begin
         values[k] = NUM_W'(value);
         value     = value + $urandom_range(0, step_max);
      end
      for (int k = 0; k < n; k++) begin
         idx = descending ? n - 1 - k : k;
         offer(write_item(idx, values[idx], sparse_bits()), 1'b0, '0);
         random_items++;
      end
   endtask

   task automatic run_lookups(input int n, input int total);
      int               pick;
      logic [NUM_W-1:0] key;
      for (int k = 0; k < total; k++) begin
         pick = $urandom_range(0, n - 1);
         if ($urandom_range(0, 9) == 0) begin
            offer(write_item($urandom_range(0, DEPTH - 1), NUM_W'($urandom()), sparse_bits()),
                  1'b0, '0);
         end else begin
            case ($urandom_range(0, 4))
               0: key = NUM_W'($urandom());
               1: key = number_copy[pick] + NUM_W'(1);
               2: key = number_copy[pick] - NUM_W'(1);
               default: key = number_copy[pick];
            endcase
            offer(lookup_item(key), 1'b0, '0);
         end
         random_items++;
      end
   endtask

   initial begin
      int               phase;
      int               n;
      logic [COUNT_W-1:0] count;
      logic [NUM_W-1:0]   mask;
      foreach (number_copy[k]) begin
         number_copy[k] = '0;
         usage_copy[k]  = '0;
         written[k]     = 1'b0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_register(REG_ENTRY_COUNT, CSR_DATA_W'(ENTRY_COUNT_RESET));
      check_register(REG_USAGE_MASK, CSR_DATA_W'(USAGE_MASK_RESET));

      configure(COUNT_W'(4), USAGE_MASK_RESET);
      foreach (SCRIPT[k]) offer(SCRIPT[k].item, SCRIPT[k].typed, SCRIPT[k].answer);
      settle();

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase < FORCED) begin
            count = FORCED_COUNT[phase];
            mask  = FORCED_MASK[phase];
         end else begin
            count = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom())
                                                : COUNT_W'($urandom_range(2, 40));
            mask  = sparse_bits();
         end
         // The full-size phase runs a long stretch without any idling on either side.
         quiet <= (phase == 3);
         configure(count, mask);
         n = effective_entries(count);
         // Large tables are loaded once and then reused.
         if (n <= 64 || !entries_ready(n)) fill_entries(n);
         if (phase == 5) hold_request <= 1'b1;
         run_lookups(n, (phase == 3) ? 200 : (phase == 5) ? 60 : $urandom_range(8, 60));
         settle();
         phase++;
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("sorted_table_binary_lookup_top regression: pass");
      else
         $display("sorted_table_binary_lookup_top regression: fail");
      $finish;
   end

endmodule
